[design/chi_square_uniformity_test_defines.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the chi-square uniformity test block
// Concurrent checks in simulation; they expand to nothing in synthesis.
// -----------------------------------------------------------------------------
`ifndef CHI_SQUARE_UNIFORMITY_TEST_DEFINES_SVH
`define CHI_SQUARE_UNIFORMITY_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CHISQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("chi-square block: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define CHISQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("chi-square block: next-cycle check failed");
`else
`define CHISQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CHISQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/chisq_pkg.sv]
// -----------------------------------------------------------------------------
// Chi-square test package
// Shared widths, reset values, register indexes, sequencer states and the
// request and response bundles of the shared divider.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chisq_pkg;

    localparam int DEF_MAX_BINS    = 128;
    localparam int DEF_SAMPLE_BITS = 24;

    // Bin counts, sample counts and the test length share one width.
    localparam int CNT_W = 21;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int CHI_W = 56;
    // Dividend width of the divider; covers the scaled sum for up to 1024 bins.
    localparam int DIV_W = 64;

    localparam int CFG_ADDR_W = 1;
    localparam int NB_CFG_W   = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_BINS         = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES_PER_TEST = 1'b1;

    localparam logic [NB_CFG_W-1:0] NUM_BINS_RST = 8'd100;
    localparam logic [CNT_W-1:0]    SAMPLES_RST  = 21'd10000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_INC,
        ST_E_START,
        ST_E_WAIT,
        ST_SWEEP,
        ST_C_START,
        ST_C_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[design/chisq_hist.sv]
// -----------------------------------------------------------------------------
// Histogram memory
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chisq_hist #(
    parameter int MAX_BINS = chisq_pkg::DEF_MAX_BINS
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_BINS)-1:0]   i_waddr,
    input  logic [chisq_pkg::CNT_W-1:0]   i_wdata,
    input  logic [$clog2(MAX_BINS)-1:0]   i_raddr,
    output logic [chisq_pkg::CNT_W-1:0]   o_rdata
);
    import chisq_pkg::*;

    logic [CNT_W-1:0] r_mem [MAX_BINS];
    logic [CNT_W-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/chisq_div.sv]
// -----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chisq_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chisq_pkg::t_div_req  i_req,
    output chisq_pkg::t_div_rsp  o_rsp
);
    import chisq_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;

    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    logic           ge;

    // The quotient register shifts the dividend out at the top and the
    // quotient bits in at the bottom.
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[design/chi_square_uniformity_test.sv]
// -----------------------------------------------------------------------------
// Chi-square uniformity test
// Histograms uniform samples and reports the chi-square statistic per test.
// -----------------------------------------------------------------------------
// Each sample on the input stream is an unsigned fraction of one and lands in
// bin floor(sample * num_bins); a test closes once samples_per_test samples
// have been taken, and one result transaction then reports chi-square in
// unsigned Q.8 (saturated at 2^56 - 1), or a set expected_zero flag with a
// zero statistic when samples_per_test / num_bins is zero. A sample goes
// through accept, histogram read and histogram write back, set by the
// read-modify-write on the single histogram memory, before the next one is
// taken. The closing sample adds the two divides of the shared 64-step
// divider and a pass over the histogram, which also clears it; when
// expected_zero is set the second divide is skipped. After reset the block
// runs a clearing pass over all MAX_BINS bins before taking its first
// sample; configuration writes are taken at any time. A finished result sits
// in an output register, so the next test proceeds while it waits.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chi_square_uniformity_test_defines.svh"

module chi_square_uniformity_test #(
    parameter int MAX_BINS    = chisq_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = chisq_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Configuration write port: index 0 is num_bins, index 1 samples_per_test.
    input  logic                                 i_cfg_we,
    input  logic [chisq_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [chisq_pkg::CNT_W-1:0]          i_cfg_data,

    // Sample stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // sample

    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [chisq_pkg::CHI_W-1:0]          m_axis_tdata,   // chi_square_q8
    output logic [0:0]                           m_axis_tuser    // expected_zero
);
    import chisq_pkg::*;

    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int BC_W   = $clog2(MAX_BINS + 1);
    localparam int NB_W   = (BC_W > NB_CFG_W) ? BC_W : NB_CFG_W;
    localparam int SW_W   = $clog2(MAX_BINS + 4);
    localparam int SUM_W  = 2 * CNT_W + BIN_W;
    localparam int PROD_W = SAMPLE_BITS + BC_W;
    localparam int SQ_W   = 2 * CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers and their effective values
    // ------------------------------------------------------------------
    logic [NB_CFG_W-1:0] r_num_bins;
    logic [CNT_W-1:0]    r_samples;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins <= NUM_BINS_RST;
            r_samples  <= SAMPLES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NUM_BINS:         r_num_bins <= i_cfg_data[NB_CFG_W-1:0];
                CFG_SAMPLES_PER_TEST: r_samples  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [NB_W-1:0]  nb_ext;
    logic [BC_W-1:0]  bins_eff;
    logic [CNT_W-1:0] len;

    // A bin count of zero acts as one, and one above MAX_BINS as MAX_BINS;
    // a zero test length acts as one.
    always_comb begin
        nb_ext = NB_W'(r_num_bins);
        if (nb_ext == '0) begin
            bins_eff = BC_W'(1);
        end else if (nb_ext > NB_W'(MAX_BINS)) begin
            bins_eff = BC_W'(MAX_BINS);
        end else begin
            bins_eff = BC_W'(nb_ext);
        end
        len = (r_samples == '0) ? CNT_W'(1) : r_samples;
    end

    // ------------------------------------------------------------------
    // Bin index of the incoming sample
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod;
    logic [BC_W-1:0]   idx_full;
    logic [BIN_W-1:0]  idx_new;

    always_comb begin
        prod     = PROD_W'(s_axis_tdata[SAMPLE_BITS-1:0]) * PROD_W'(bins_eff);
        idx_full = prod[PROD_W-1:SAMPLE_BITS];
        if (idx_full >= bins_eff) begin
            idx_new = BIN_W'(bins_eff - BC_W'(1));
        end else begin
            idx_new = BIN_W'(idx_full);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [BIN_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic [SW_W-1:0]  r_swp;
    logic [CNT_W-1:0] r_e;
    logic             r_e_zero;
    logic [SUM_W-1:0] r_sum;
    logic [CHI_W-1:0] r_chi;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic [CNT_W-1:0] r_diff;
    logic [SQ_W-1:0]  r_sq;

    logic             r_out_valid;
    logic [CHI_W-1:0] r_out_chi;
    logic             r_out_ez;

    // Histogram and divider connections.
    logic             mem_we;
    logic [BIN_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [BIN_W-1:0] mem_raddr;
    logic [CNT_W-1:0] mem_rdata;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic             in_ready;
    logic             out_load;

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] bin_inc;
    logic             close;
    logic             swp_issue;
    logic             swp_acc;
    logic [CNT_W-1:0] abs_diff;

    always_comb begin
        cnt_inc   = (r_count == CNT_MAX) ? r_count : r_count + CNT_W'(1);
        bin_inc   = (mem_rdata == CNT_MAX) ? mem_rdata : mem_rdata + CNT_W'(1);
        close     = (cnt_inc >= len);
        swp_issue = (r_swp < SW_W'(MAX_BINS));
        // Only bins below the current bin count take part in the sum.
        swp_acc   = swp_issue && (r_swp < SW_W'(bins_eff)) && !r_e_zero;
        abs_diff  = (mem_rdata >= r_e) ? mem_rdata - r_e : r_e - mem_rdata;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_swp == SW_W'(MAX_BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_INC;
            ST_INC: begin
                n_state = close ? ST_E_START : ST_IDLE;
            end
            ST_E_START: n_state = ST_E_WAIT;
            ST_E_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_swp == SW_W'(MAX_BINS + 3)) begin
                    n_state = r_e_zero ? ST_EMIT : ST_C_START;
                end
            end
            ST_C_START: n_state = ST_C_WAIT;
            ST_C_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory port, divider request and handshake.
    always_comb begin
        in_ready         = 1'b0;
        out_load         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = r_idx;
        mem_wdata        = '0;
        mem_raddr        = r_idx;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(len);
        div_req.divisor  = CNT_W'(bins_eff);
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_swp[BIN_W-1:0];
            end
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_INC: begin
                mem_we    = 1'b1;
                mem_wdata = bin_inc;
            end
            ST_E_START: begin
                div_req.start = 1'b1;
            end
            ST_SWEEP: begin
                // Each bin is read for the sum and zeroed in the same cycle.
                mem_we    = swp_issue;
                mem_waddr = r_swp[BIN_W-1:0];
                mem_raddr = r_swp[BIN_W-1:0];
            end
            ST_C_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({r_sum, 8'd0});
                div_req.divisor  = r_e;
            end
            ST_EMIT: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_swp       <= '0;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR || r_state == ST_SWEEP) begin
                r_swp <= r_swp + SW_W'(1);
            end else begin
                r_swp <= '0;
            end
            if (r_state == ST_INC) begin
                r_count <= close ? '0 : cnt_inc;
            end
            r_v1 <= (r_state == ST_SWEEP) && swp_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers: a three-stage sweep pipeline of difference,
    // square and accumulate behind the registered memory read.
    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_idx <= idx_new;
        end
        r_diff <= abs_diff;
        r_sq   <= r_diff * r_diff;
        if (r_state == ST_E_WAIT && div_rsp.done) begin
            r_e      <= div_rsp.quotient[CNT_W-1:0];
            r_e_zero <= (div_rsp.quotient == '0);
            r_sum    <= '0;
        end else if (r_v3) begin
            r_sum <= r_sum + SUM_W'(r_sq);
        end
        if (r_state == ST_C_WAIT && div_rsp.done) begin
            if (|div_rsp.quotient[DIV_W-1:CHI_W]) begin
                r_chi <= '1;
            end else begin
                r_chi <= div_rsp.quotient[CHI_W-1:0];
            end
        end
        if (out_load) begin
            r_out_chi <= r_e_zero ? '0 : r_chi;
            r_out_ez  <= r_e_zero;
        end
    end

    // ------------------------------------------------------------------
    // Histogram memory and shared divider
    // ------------------------------------------------------------------
    chisq_hist #(
        .MAX_BINS (MAX_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    chisq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready   = in_ready;
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_chi;
    assign m_axis_tuser[0] = r_out_ez;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CHISQ_ASSERT_IMP(a_no_sample_during_divide, i_clk, i_rst_n, s_axis_tready, !div_rsp.busy)
    `CHISQ_ASSERT_IMP(a_done_only_when_waited, i_clk, i_rst_n, div_rsp.done,
        (r_state == ST_E_WAIT || r_state == ST_C_WAIT))
    `CHISQ_ASSERT_NXT(a_emit_fills_output, i_clk, i_rst_n,
        (r_state == ST_EMIT && !r_out_valid), (r_out_valid && r_state == ST_IDLE))

endmodule

[sim/chi_square_uniformity_test_checker.sv]
// -----------------------------------------------------------------------------
// Chi-square uniformity test checker
// Watches the configuration port and both streams, keeps its own histogram
// and predicts every chi-square result, comparing each one as it leaves.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chi_square_uniformity_test_checker #(
    parameter int MAX_BINS    = chisq_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = chisq_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_we,
    input  logic [chisq_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [chisq_pkg::CNT_W-1:0]          i_cfg_data,

    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,   // sample

    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [chisq_pkg::CHI_W-1:0]          i_m_tdata,   // chi_square_q8
    input  logic [0:0]                           i_m_tuser,   // expected_zero

    output int                                   o_mismatch_count,
    output int                                   o_results_due
);

    localparam logic [63:0] CHI_LIMIT = (64'd1 << chisq_pkg::CHI_W) - 64'd1;

    typedef struct {
        logic [chisq_pkg::CHI_W-1:0] chi_q8;
        logic                        expected_zero;
    } t_chi_result;

    t_chi_result                  chi_due[$];
    logic [chisq_pkg::CNT_W-1:0]  bin_count [MAX_BINS];
    logic [chisq_pkg::CNT_W-1:0]  taken;
    logic [chisq_pkg::NB_CFG_W-1:0] bins_cfg;
    logic [chisq_pkg::CNT_W-1:0]  length_cfg;
    int                           mismatch_count = 0;

    // Adds one sample to the histogram and, on the closing sample of a test,
    // queues the chi-square result and empties the histogram.
    task automatic tally_sample(input logic [SAMPLE_BITS-1:0] smp);
        int unsigned bins_used;
        int unsigned len;
        int unsigned e;
        logic [63:0] idx;
        logic [63:0] sum;
        logic [63:0] diff;
        logic [63:0] chi;
        t_chi_result res;
        bins_used = (bins_cfg == 0) ? 1 : (bins_cfg > MAX_BINS) ? MAX_BINS : bins_cfg;
        len  = (length_cfg == 0) ? 1 : length_cfg;
        idx  = (64'(smp) * 64'(bins_used)) >> SAMPLE_BITS;
        if (idx >= bins_used) idx = bins_used - 1;
        if (bin_count[idx] != chisq_pkg::CNT_MAX) bin_count[idx]++;
        if (taken != chisq_pkg::CNT_MAX) taken++;
        if (taken >= len) begin
            e = len / bins_used;
            if (e == 0) begin
                res.chi_q8        = '0;
                res.expected_zero = 1'b1;
            end else begin
                sum = '0;
                for (int b = 0; b < bins_used; b++) begin
                    diff = (64'(bin_count[b]) >= 64'(e)) ? 64'(bin_count[b]) - 64'(e)
                                                        : 64'(e) - 64'(bin_count[b]);
                    sum += diff * diff;
                end
                chi = (sum << 8) / 64'(e);
                if (chi > CHI_LIMIT) chi = CHI_LIMIT;
                res.chi_q8        = chi[chisq_pkg::CHI_W-1:0];
                res.expected_zero = 1'b0;
            end
            chi_due.push_back(res);
            foreach (bin_count[b]) bin_count[b] = '0;
            taken = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_chi_result want;
        if (!i_rst_n) begin
            foreach (bin_count[b]) bin_count[b] = '0;
            taken      = '0;
            bins_cfg   = chisq_pkg::NUM_BINS_RST;
            length_cfg = chisq_pkg::SAMPLES_RST;
            chi_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    chisq_pkg::CFG_NUM_BINS: begin
                        bins_cfg = i_cfg_data[chisq_pkg::NB_CFG_W-1:0];
                    end
                    chisq_pkg::CFG_SAMPLES_PER_TEST: begin
                        length_cfg = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) tally_sample(i_s_tdata[SAMPLE_BITS-1:0]);
            if (i_m_tvalid && i_m_tready) begin
                if (chi_due.size() == 0) begin
                    $error("unexpected result: chi_square_q8 %0d, expected_zero %0b",
                           i_m_tdata, i_m_tuser);
                    mismatch_count++;
                end else begin
                    want = chi_due.pop_front();
                    if (i_m_tdata !== want.chi_q8) begin
                        $error("chi_square_q8: expected %0d, got %0d", want.chi_q8, i_m_tdata);
                        mismatch_count++;
                    end
                    if (i_m_tuser[0] !== want.expected_zero) begin
                        $error("expected_zero: expected %0b, got %0b",
                               want.expected_zero, i_m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
        end
        o_results_due    <= chi_due.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

[sim/chi_square_uniformity_test_tb.sv]
// -----------------------------------------------------------------------------
// Chi-square uniformity test bench
// Drives sample streams under a range of bin counts and test lengths, with
// random idling on both streams and one long back-pressure spell; a checker
// beside the block predicts and compares every result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chi_square_uniformity_test_tb;

    localparam int MAX_BINS    = chisq_pkg::DEF_MAX_BINS;
    localparam int SAMPLE_BITS = chisq_pkg::DEF_SAMPLE_BITS;
    localparam int SMP_W       = ((SAMPLE_BITS + 7) / 8) * 8;

    // A closing sample costs up to two divides and a pass over the histogram,
    // both covered by this pause; it is also the settling pause before any
    // register write, since a sample that closes no test leaves nothing to
    // wait for on the result side.
    localparam int SETTLE_CYCLES   = 300;
    // The longest correct stretch without a transaction is the back-pressure
    // spell below plus one closing pass; the limit is several times that.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int ITEM_TARGET     = 550;
    localparam int RESULT_TARGET   = 48;

    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = '1;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_we      = 1'b0;
    logic [chisq_pkg::CFG_ADDR_W-1:0]   i_cfg_addr    = '0;
    logic [chisq_pkg::CNT_W-1:0]        i_cfg_data    = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [SMP_W-1:0]                   s_axis_tdata  = '0;   // sample
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [chisq_pkg::CHI_W-1:0]        m_axis_tdata;         // chi_square_q8
    logic [0:0]                         m_axis_tuser;         // expected_zero

    int mismatch_count;
    int results_due;
    int items_sent    = 0;
    int results_seen  = 0;
    int idle_cycles   = 0;

    // Shared between the stimulus and the result sink: a phase with no idling
    // at all, and the one-off request for a long hold-off on the result side.
    bit no_gaps       = 1'b0;
    bit stall_request = 1'b0;
    bit stall_done    = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    chi_square_uniformity_test #(
        .MAX_BINS      (MAX_BINS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    chi_square_uniformity_test_checker #(
        .MAX_BINS         (MAX_BINS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tuser        (m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    // Watchdog: any transaction on either stream restarts the count. The
    // result count is kept here as well, since it decides when the random
    // part may stop.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT - 1) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink. Before each transaction it waits a random number of
    // cycles with tready low. When the stimulus asks for it, it holds off
    // once for a long spell, so that the block's output register fills and
    // the sample stream backs up behind it.
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (stall_request && !stall_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                stall_done = 1'b1;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // One register write. The enable is dropped for a cycle afterwards, so
    // two writes in a row never assign it twice within one time step.
    task automatic write_reg(input logic [chisq_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [chisq_pkg::CNT_W-1:0]      data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one sample after a random gap and returns at the edge where the
    // transaction completes. tvalid stays high into the next sample when
    // there is no gap.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= SMP_W'(smp);
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    // Ends a phase: the stream goes quiet, every outstanding result is
    // collected, and the block is then given time to finish the last
    // samples before the registers may change. The extra edge lets the
    // checker's count take in the final sample.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly uniform samples with the two extremes mixed in. A skewed phase
    // crowds the samples into the lowest eighth of the range, which gives
    // large statistics.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input bit skewed);
        logic [SAMPLE_BITS-1:0] smp;
        case ($urandom_range(0, 9))
            0:       smp = '0;
            1:       smp = SMP_MAX;
            default: smp = skewed ? SAMPLE_BITS'($urandom_range(0, SMP_MAX >> 3))
                                  : SAMPLE_BITS'($urandom);
        endcase
        return smp;
    endfunction

    initial begin
        int unsigned nb;
        int unsigned spt;
        int unsigned eff_bins;
        int unsigned n_items;
        bit          skewed;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero bins and zero test length both act as one: every sample is a
        // test of its own, with a zero statistic.
        write_reg(chisq_pkg::CFG_NUM_BINS, 0);
        write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, 0);
        send_sample('0);
        send_sample(SMP_MAX);
        settle();

        // A bin count beyond the maximum saturates; three samples over that
        // many bins leave an expected count of zero, so the expected_zero flag is set.
        write_reg(chisq_pkg::CFG_NUM_BINS, 255);
        write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, 3);
        send_sample(SMP_MAX);
        send_sample('0);
        send_sample(SAMPLE_BITS'(24'h7F_FFFF));
        settle();

        // The longest test length with a partial test in the histogram, then
        // the length lowered to the number of samples already taken: the very next
        // sample closes the test.
        write_reg(chisq_pkg::CFG_NUM_BINS, 2);
        write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, chisq_pkg::CNT_MAX);
        send_sample(SMP_MAX);
        send_sample(SAMPLE_BITS'(24'h00_0001));
        send_sample(SAMPLE_BITS'(24'h80_0000));
        send_sample(SAMPLE_BITS'(24'h02_0000));
        settle();
        write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, 4);
        send_sample(SAMPLE_BITS'(24'h7F_FFFF));
        settle();

        // The bin count is cut while a test runs: counts above the new top
        // bin take no part in the closing sum, yet are cleared with the rest.
        write_reg(chisq_pkg::CFG_NUM_BINS, 8);
        write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, 1048576);
        send_sample(SMP_MAX);
        send_sample(SAMPLE_BITS'(24'hE0_0000));
        send_sample(SAMPLE_BITS'(24'h10_0000));
        settle();
        write_reg(chisq_pkg::CFG_NUM_BINS, 2);
        write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, 6);
        send_sample(SAMPLE_BITS'(24'h40_0000));
        send_sample(SAMPLE_BITS'(24'hC0_0000));
        send_sample(SAMPLE_BITS'(24'h80_0000));
        settle();

        // Back-pressure: short tests offered with no gaps while the sink
        // holds off, so the block fills up and stalls its input.
        write_reg(chisq_pkg::CFG_NUM_BINS, 2);
        write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, 2);
        no_gaps       <= 1'b1;
        stall_request <= 1'b1;
        repeat (60) send_sample(pick_sample(1'b0));
        settle();

        // Random phases. Each picks a setting, sometimes changing only one
        // register so that a test left open carries into the next setting,
        // and then sends a random number of samples.
        while (items_sent < ITEM_TARGET || results_seen < RESULT_TARGET) begin
            case ($urandom_range(0, 9))
                0:       nb = 0;
                1:       nb = 1;
                2:       nb = MAX_BINS;
                3:       nb = 255;
                4:       nb = $urandom_range(MAX_BINS + 1, 255);
                5, 6:    nb = $urandom_range(1, MAX_BINS);
                default: nb = $urandom_range(2, 12);
            endcase
            eff_bins = (nb == 0) ? 1 : (nb > MAX_BINS) ? MAX_BINS : nb;
            case ($urandom_range(0, 9))
                0:       spt = 0;
                1:       spt = 1;
                2:       spt = $urandom_range(0, eff_bins - 1);
                3:       spt = $urandom_range(200, 600);
                default: spt = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    write_reg(chisq_pkg::CFG_NUM_BINS, chisq_pkg::CNT_W'(nb));
                end
                1: begin
                    write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, chisq_pkg::CNT_W'(spt));
                end
                default: begin
                    write_reg(chisq_pkg::CFG_NUM_BINS, chisq_pkg::CNT_W'(nb));
                    write_reg(chisq_pkg::CFG_SAMPLES_PER_TEST, chisq_pkg::CNT_W'(spt));
                end
            endcase
            no_gaps <= ($urandom_range(0, 4) == 0);
            skewed   = ($urandom_range(0, 3) == 0);
            n_items  = $urandom_range(5, 60);
            repeat (n_items) send_sample(pick_sample(skewed));
            settle();
        end

        if (mismatch_count == 0 && results_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/chisq_pkg.sv
design/chisq_hist.sv
design/chisq_div.sv
design/chi_square_uniformity_test.sv
sim/chi_square_uniformity_test_checker.sv
sim/chi_square_uniformity_test_tb.sv
